[hdl/irp_pkg.sv]
// ----------------------------------------------------------------------------
// irp_pkg: shared types and constants of the input report parser
// Record kinds, lengths, Q points and the command beat between the parse
// front and the record assembly back end.
// ----------------------------------------------------------------------------
package irp_pkg;

  localparam int unsigned NumIds   = 6;
  localparam int unsigned NumSlots = 10;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  localparam logic [7:0] TimestampId  = 8'hFB;
  localparam logic [3:0] TimestampLen = 4'd5;

  localparam logic [2:0] KindAccel   = 3'd0;
  localparam logic [2:0] KindGyro    = 3'd1;
  localparam logic [2:0] KindMagnet  = 3'd2;
  localparam logic [2:0] KindLinAcc  = 3'd3;
  localparam logic [2:0] KindRot     = 3'd4;
  localparam logic [2:0] KindGameRot = 3'd5;
  localparam logic [2:0] KindUnknown = 3'd7;

  // register defaults, index order of the config port
  localparam logic [7:0] IdReset [NumIds] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8};

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,  // update the held calibration status
    OP_STORE  = 2'd1,  // store one record byte
    OP_EMIT   = 2'd2   // store the final record byte and emit the report
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [7:0]       data;
    logic [2:0]       kind;
  } cmd_t;

  typedef struct packed {
    logic valid;  // queue holds at least one beat
    logic full;   // queue cannot take another beat
  } q_stat_t;

  function automatic logic [3:0] kind_len(input logic [2:0] kind);
    logic [3:0] len;
    unique case (kind)
      KindRot:     len = 4'd14;
      KindGameRot: len = 4'd12;
      default:     len = 4'd10;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] kind_frac_bits(input logic [2:0] kind);
    logic [3:0] fb;
    unique case (kind) inside
      KindGyro:                fb = 4'd9;
      KindMagnet:              fb = 4'd4;
      KindRot, KindGameRot:    fb = 4'd14;
      default:                 fb = 4'd8;
    endcase
    return fb;
  endfunction

endpackage

[hdl/irp_front.sv]
// ----------------------------------------------------------------------------
// irp_front: byte parser
// Tracks record framing, looks up report IDs and turns the status and
// record bytes into command beats for the back end.
// ----------------------------------------------------------------------------
module irp_front import irp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] id_q [NumIds];
  logic [3:0] pos_q, pos_d;
  logic [2:0] kind_q, kind_d;
  logic       skip_q, skip_d;
  logic       discard_q, discard_d;
  logic [1:0] stat_q, stat_d;
  logic [2:0] lookup;
  logic       emit;

  // lowest-numbered matching register wins
  always_comb begin
    lookup = KindUnknown;
    for (int i = NumIds - 1; i >= 0; i--) begin
      if (id_q[i] == data_byte_i) lookup = 3'(i);
    end
  end

  always_comb begin
    pos_d     = pos_q;
    kind_d    = kind_q;
    skip_d    = skip_q;
    discard_d = discard_q;
    stat_d    = stat_q;
    push_o    = 1'b0;
    cmd_o     = '{op: OP_STORE, slot: SlotW'(pos_q - 4'd4), data: data_byte_i, kind: kind_q};
    emit      = (kind_q <= KindGameRot) && (pos_q >= 4'd4) &&
                (pos_q + 4'd1 == kind_len(kind_q));
    if (discard_q) begin
      // drop everything until the payload end
    end else if (skip_q) begin
      if (pos_q + 4'd1 >= TimestampLen) begin
        pos_d  = '0;
        skip_d = 1'b0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end else if (pos_q == '0) begin
      if (data_byte_i == TimestampId) begin
        skip_d = 1'b1;
      end else begin
        kind_d = lookup;
      end
      pos_d = 4'd1;
    end else begin
      if (pos_q == 4'd2) stat_d = data_byte_i[1:0];
      if (pos_q == 4'd3) begin
        push_o     = accept_i;
        cmd_o.op   = OP_STATUS;
        cmd_o.data = {6'd0, stat_q};
        if (kind_q > KindGameRot) discard_d = 1'b1;
      end
      if (pos_q >= 4'd4) begin
        push_o   = accept_i;
        cmd_o.op = emit ? OP_EMIT : OP_STORE;
      end
      if (emit) begin
        pos_d = '0;
      end else if (!discard_d) begin
        pos_d = pos_q + 4'd1;
      end
    end
    if (last_byte_i) begin
      pos_d     = '0;
      kind_d    = '0;
      skip_d    = 1'b0;
      discard_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      kind_q    <= '0;
      skip_q    <= 1'b0;
      discard_q <= 1'b0;
      stat_q    <= '0;
      for (int i = 0; i < NumIds; i++) id_q[i] <= IdReset[i];
    end else begin
      if (accept_i) begin
        pos_q     <= pos_d;
        kind_q    <= kind_d;
        skip_q    <= skip_d;
        discard_q <= discard_d;
        stat_q    <= stat_d;
      end
      if (cfg_we_i && (cfg_index_i < 3'(NumIds))) id_q[cfg_index_i] <= cfg_data_i;
    end
  end

endmodule

[hdl/irp_fifo.sv]
// ----------------------------------------------------------------------------
// irp_fifo: command queue
// Small register FIFO between parse front and record back end.
// ----------------------------------------------------------------------------
module irp_fifo import irp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_o        = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i)  rd_q <= bump(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hdl/irp_back.sv]
// ----------------------------------------------------------------------------
// irp_back: record assembly
// Holds record bytes and calibration status, builds the report and keeps
// it in the output register until taken.
// ----------------------------------------------------------------------------
module irp_back import irp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         report_kind_o,
  output logic [1:0]         cal_status_o,
  output logic signed [15:0] value_x_o,
  output logic signed [15:0] value_y_o,
  output logic signed [15:0] value_z_o,
  output logic signed [15:0] value_real_o,
  output logic signed [15:0] accuracy_estimate_o,
  output logic [3:0]         q_point_o
);

  logic [7:0] slot_q [NumSlots];
  logic [7:0] view   [NumSlots];
  logic [1:0] held_q;
  logic       out_free, wr, emit;

  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = q_stat_i.valid && ((cmd_i.op != OP_EMIT) || out_free);
  assign wr       = pop_o && (cmd_i.op != OP_STATUS);
  assign emit     = pop_o && (cmd_i.op == OP_EMIT);

  // final byte bypasses into the words
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      view[i] = (wr && cmd_i.slot == SlotW'(i)) ? cmd_i.data : slot_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[cmd_i.slot] <= cmd_i.data;
    if (emit) begin
      report_kind_o  <= cmd_i.kind;
      cal_status_o   <= held_q;
      value_x_o      <= {view[1], view[0]};
      value_y_o      <= {view[3], view[2]};
      value_z_o      <= {view[5], view[4]};
      value_real_o   <= (cmd_i.kind == KindRot || cmd_i.kind == KindGameRot) ?
                        {view[7], view[6]} : '0;
      accuracy_estimate_o <= (cmd_i.kind == KindRot) ? {view[9], view[8]} : '0;
      q_point_o      <= kind_frac_bits(cmd_i.kind);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (pop_o && cmd_i.op == OP_STATUS) held_q <= cmd_i.data[1:0];
      if (out_free) out_valid_o <= emit;
    end
  end

endmodule

[hdl/imu_input_report_parser_top.sv]
// ----------------------------------------------------------------------------
// imu_input_report_parser_top: sensor hub input report parser
// Splits a byte stream into records and emits raw Q-format report words.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one payload byte per beat (data_byte_i), last_byte_i
//    marks the final byte of a payload. Beat taken when in_valid_i and
//    !in_stall_o.
//  - Output channel: one report per beat, taken when out_valid_o and
//    !out_stall_i. Only complete records of a known ID make a report.
//  - Config: cfg_we_i writes cfg_data_i into ID register cfg_index_i
//    (0..5); other indexes are ignored. Write only while idle.
//  - Throughput: one byte per cycle while in_stall_o is low. Constant work
//    per byte in the front parser and in the back end, at most one queue beat each.
//  - Report path: the record's final byte is written into the queue, then
//    the back end pops it into the output register and out_valid_o rises
//    (the pop waits while a stalled report is held).
//  - Reset: ID registers return to 1,2,3,4,5,8, framing and held status
//    clear, queue and output register empty.
//  - Receiver stall: the output register holds its report; the queue
//    (QueueDepth beats) keeps absorbing bytes, then in_stall_o rises.
// ----------------------------------------------------------------------------
module imu_input_report_parser_top import irp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         report_kind_o,
  output logic [1:0]         cal_status_o,
  output logic signed [15:0] value_x_o,
  output logic signed [15:0] value_y_o,
  output logic signed [15:0] value_z_o,
  output logic signed [15:0] value_real_o,
  output logic signed [15:0] accuracy_estimate_o,
  output logic [3:0]         q_point_o
);

  logic    accept, push, pop;
  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;

  // stall only on a full queue; every byte is consumed by the front
  assign in_stall_o = q_stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  irp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  irp_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  irp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (head_cmd),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .report_kind_o       (report_kind_o),
    .cal_status_o        (cal_status_o),
    .value_x_o           (value_x_o),
    .value_y_o           (value_y_o),
    .value_z_o           (value_z_o),
    .value_real_o        (value_real_o),
    .accuracy_estimate_o (accuracy_estimate_o),
    .q_point_o           (q_point_o)
  );

  // a full queue is never empty
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> q_stat.valid) else $error("queue full but empty");

  // only known kinds are reported
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> report_kind_o <= KindGameRot) else $error("bad report kind");

  // accuracy word exists only in rotation vector records
  a_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o != KindRot |-> accuracy_estimate_o == '0)
    else $error("accuracy set on non-rotation report");

  // three-axis kinds carry no real part
  a_real_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o < KindRot |-> value_real_o == '0)
    else $error("real part set on three-axis report");

endmodule
